// ===== sv/selu_pkg.sv =====
`timescale 1ns / 1ps

package selu_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RESULT_W = 20;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned AL_W     = 2 * COEF_W;

  // exp knots are Q30, so 1.0 needs 31 bits
  localparam int unsigned KNOT_W   = 31;
  localparam int unsigned FRAC_W   = 15;
  localparam logic [KNOT_W-1:0] ONE_Q30 = KNOT_W'(64'd1 << 30);

  // Configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic REG_ALPHA  = 1'b0;
  localparam logic REG_LAMBDA = 1'b1;

  localparam logic [COEF_W-1:0] ALPHA_RESET  = 16'd27415;
  localparam logic [COEF_W-1:0] LAMBDA_RESET = 16'd17215;
  localparam logic [AL_W-1:0]   AL_RESET     =
    AL_W'(AL_W'(ALPHA_RESET) * AL_W'(LAMBDA_RESET));

  // Result limits, held one bit wider than the port
  localparam int unsigned RES_W = RESULT_W + 1;
  localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(524287);
  localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(524288);

  // Scale factors handed from the register block to the datapath
  typedef struct packed {
    logic [COEF_W-1:0] lambda;
    logic [AL_W-1:0]   al;      // alpha * lambda, Q28
  } selu_cfg_t;

endpackage

// ===== sv/selu_apb_regs.sv =====
`timescale 1ns / 1ps

module selu_apb_regs import selu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output selu_cfg_t          cfg_o
);

  logic [COEF_W-1:0] alpha_q, alpha_d;
  logic [COEF_W-1:0] lambda_q, lambda_d;
  logic [AL_W-1:0]   al_q, al_d;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes
  always_comb begin
    alpha_d  = alpha_q;
    lambda_d = lambda_q;
    if (wr_en) begin
      case (reg_sel)
        REG_ALPHA:  alpha_d  = pwdata[COEF_W-1:0];
        REG_LAMBDA: lambda_d = pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Combined scale for the negative branch, registered from the alpha and lambda registers
  assign al_d = AL_W'(alpha_q) * AL_W'(lambda_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      lambda_q <= LAMBDA_RESET;
      al_q     <= AL_RESET;
    end else begin
      alpha_q  <= alpha_d;
      lambda_q <= lambda_d;
      al_q     <= al_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_ALPHA:  prdata = PDATA_W'(alpha_q);
      REG_LAMBDA: prdata = PDATA_W'(lambda_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.lambda = lambda_q;
  assign cfg_o.al     = al_q;

endmodule

// ===== sv/selu_exp_rom.sv =====
`timescale 1ns / 1ps

module selu_exp_rom import selu_pkg::*; #(
  parameter int unsigned EXP_SEGMENTS = 64
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [$clog2(EXP_SEGMENTS+1)-1:0]   idx_i,
  output logic [KNOT_W-1:0]                   knot_o,
  output logic [KNOT_W-1:0]                   diff_o
);

  localparam int unsigned IDX_W = $clog2(EXP_SEGMENTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXP_SEGMENTS);

  typedef logic [EXP_SEGMENTS:0][KNOT_W-1:0] knot_tab_t;

  // Shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Knot k = exp(-16*k/EXP_SEGMENTS) in Q30, built by repeated scaling
  function automatic knot_tab_t build_knots();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] prod;
    knot_tab_t   tab;
    term = 64'd1 << 30;
    sum  = '0;
    for (int n = 1; n <= 64; n++) begin
      if (term != 64'd0) begin
        sum  = sum + term;
        term = udiv(term * 64'd16, 64'(EXP_SEGMENTS) * 64'(n));
      end
    end
    if (sum == 64'd0) begin
      sum = 64'd1 << 30;
    end
    r = udiv((64'd1 << 60) + (sum >> 1), sum);
    tab[0] = ONE_Q30;
    for (int k = 1; k <= EXP_SEGMENTS; k++) begin
      prod   = 64'(tab[k-1]) * r + (64'd1 << 29);
      tab[k] = KNOT_W'(prod >> 30);
    end
    return tab;
  endfunction

  // Drop to the next knot; zero at the last knot
  function automatic knot_tab_t build_diffs(input knot_tab_t k);
    knot_tab_t d;
    d = '0;
    for (int i = 0; i < EXP_SEGMENTS; i++) begin
      d[i] = (k[i] >= k[i+1]) ? KNOT_W'(k[i] - k[i+1]) : '0;
    end
    return d;
  endfunction

  localparam knot_tab_t KNOTS = build_knots();
  localparam knot_tab_t DIFFS = build_diffs(KNOTS);

  logic [IDX_W-1:0]  idx_c;
  logic [KNOT_W-1:0] knot_q;
  logic [KNOT_W-1:0] diff_q;

  assign idx_c = (idx_i > LAST_IDX) ? LAST_IDX : idx_i;

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      knot_q <= KNOTS[idx_c];
      diff_q <= DIFFS[idx_c];
    end
  end

  assign knot_o = knot_q;
  assign diff_o = diff_q;

endmodule

// ===== sv/selu_pipe.sv =====
`timescale 1ns / 1ps

module selu_pipe import selu_pkg::*; #(
  parameter int unsigned EXP_SEGMENTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  selu_cfg_t                  cfg_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       sample_in_valid_i,
  output logic                       sample_in_stall_o,
  output logic signed [RESULT_W-1:0] sample_out_o,
  output logic                       sample_out_valid_o,
  input  logic                       sample_out_stall_i
);

  localparam int unsigned NSTAGE = 7;
  localparam int unsigned IDX_W  = $clog2(EXP_SEGMENTS + 1);
  localparam int unsigned POS_W  = FRAC_W + IDX_W;
  localparam int unsigned T_W    = SAMPLE_W + 1;
  localparam int unsigned PP_W   = 2 * COEF_W - 1;
  localparam int unsigned PPOS_W = PP_W + 1 - 14;
  localparam int unsigned DP_W   = KNOT_W + FRAC_W;
  localparam int unsigned MP_W   = KNOT_W + AL_W;
  localparam int unsigned MAG_W  = MP_W + 1 - 47;
  localparam logic [POS_W-1:0] SEG_C = POS_W'(EXP_SEGMENTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXP_SEGMENTS);

  // Stage valid bits and advance enables
  logic [NSTAGE:1] valid_q;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !valid_q[NSTAGE] || !sample_out_stall_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign sample_in_stall_o = !adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[1]) begin
        valid_q[1] <= sample_in_valid_i;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: capture sample
  logic signed [SAMPLE_W-1:0] x1_q;

  // Stage 2: segment position and positive product
  logic [T_W-1:0]    t;
  logic [POS_W-1:0]  pos;
  logic              neg2_q;
  logic [IDX_W-1:0]  idx2_q;
  logic [FRAC_W-1:0] frac2_q;
  logic [PP_W-1:0]   pprod2_q;

  assign t   = T_W'(~{x1_q[SAMPLE_W-1], x1_q}) + T_W'(1);
  assign pos = POS_W'(t) * SEG_C;

  // Stage 3: table read, positive rounding
  logic [KNOT_W-1:0] knot3;
  logic [KNOT_W-1:0] diff3;
  logic              neg3_q;
  logic [FRAC_W-1:0] frac3_q;
  logic [PPOS_W-1:0] ppos3_q;
  logic [PP_W:0]     ppos_sum;

  assign ppos_sum = (PP_W+1)'(pprod2_q) + (PP_W+1)'(1 << 13);

  selu_exp_rom #(
    .EXP_SEGMENTS(EXP_SEGMENTS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (adv[3]),
    .idx_i  (idx2_q),
    .knot_o (knot3),
    .diff_o (diff3)
  );

  // Stage 4: interpolation product
  logic              neg4_q;
  logic [KNOT_W-1:0] knot4_q;
  logic [DP_W-1:0]   dprod4_q;
  logic [PPOS_W-1:0] ppos4_q;

  // Stage 5: 1 - exp(x)
  logic [DP_W:0]     dsum;
  logic [KNOT_W:0]   e_raw;
  logic [KNOT_W-1:0] e_c;
  logic              neg5_q;
  logic [KNOT_W-1:0] m5_q;
  logic [PPOS_W-1:0] ppos5_q;

  assign dsum  = (DP_W+1)'(dprod4_q) + (DP_W+1)'(1 << 14);
  assign e_raw = (KNOT_W+1)'(knot4_q) - (KNOT_W+1)'(dsum[DP_W:FRAC_W]);
  assign e_c   = (e_raw > (KNOT_W+1)'(ONE_Q30)) ? ONE_Q30 : e_raw[KNOT_W-1:0];

  // Stage 6: scale by alpha*lambda
  logic              neg6_q;
  logic [MP_W-1:0]   mprod6_q;
  logic [PPOS_W-1:0] ppos6_q;

  // Stage 7: round, select branch, saturate
  logic [MP_W:0]              msum;
  logic [MAG_W-1:0]           mag;
  logic signed [RES_W-1:0]    res;
  logic signed [RESULT_W-1:0] out_q;

  assign msum = (MP_W+1)'(mprod6_q) + ((MP_W+1)'(1) << 46);
  assign mag  = msum[MP_W:47];

  always_comb begin
    if (neg6_q) begin
      res = RES_W'(0) - RES_W'(mag);
    end else begin
      res = RES_W'(ppos6_q);
    end
    if (res > OUT_MAX) begin
      res = OUT_MAX;
    end else if (res < OUT_MIN) begin
      res = OUT_MIN;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      x1_q <= sample_in_i;
    end
    if (adv[2]) begin
      neg2_q   <= x1_q[SAMPLE_W-1];
      idx2_q   <= pos[POS_W-1:FRAC_W];
      frac2_q  <= pos[FRAC_W-1:0];
      pprod2_q <= PP_W'(x1_q[SAMPLE_W-2:0]) * PP_W'(cfg_i.lambda);
    end
    if (adv[3]) begin
      neg3_q  <= neg2_q;
      frac3_q <= frac2_q;
      ppos3_q <= ppos_sum[PP_W:14];
    end
    if (adv[4]) begin
      neg4_q   <= neg3_q;
      knot4_q  <= knot3;
      dprod4_q <= DP_W'(diff3) * DP_W'(frac3_q);
      ppos4_q  <= ppos3_q;
    end
    if (adv[5]) begin
      neg5_q  <= neg4_q;
      m5_q    <= ONE_Q30 - e_c;
      ppos5_q <= ppos4_q;
    end
    if (adv[6]) begin
      neg6_q   <= neg5_q;
      mprod6_q <= MP_W'(m5_q) * MP_W'(cfg_i.al);
      ppos6_q  <= ppos5_q;
    end
    if (adv[7]) begin
      out_q <= res[RESULT_W-1:0];
    end
  end

  assign sample_out_o       = out_q;
  assign sample_out_valid_o = valid_q[NSTAGE];

  // Input is held off only when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_in_stall_o |-> (&valid_q))
    else $error("input stalled with a free stage");

  // Segment index never runs past the last knot
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[2] && neg2_q) |-> (idx2_q <= LAST_IDX))
    else $error("segment index out of range");

  // 1 - exp(x) stays within [0, 1]
  a_m_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[5] && neg5_q) |-> (m5_q <= ONE_Q30))
    else $error("1-exp(x) out of range");

  // A non-negative sample never yields a negative result
  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[6] && adv[7] && !neg6_q) |=> !sample_out_o[RESULT_W-1])
    else $error("negative result on the linear branch");

endmodule

// ===== sv/selu_activation_core.sv =====
`timescale 1ns / 1ps

// SELU activation core. Each item carries one signed Q4.11 sample and yields one
// signed Q8.11 result: lambda*x for x >= 0, lambda*alpha*(exp(x)-1) for x < 0,
// with exp taken from a table of EXP_SEGMENTS+1 Q30 knots over [-16, 0] and
// linearly interpolated. alpha (address 0) and lambda (address 4) are unsigned
// Q2.14 registers on the APB port; write them only while the core is empty.
// The datapath is a seven-stage pipeline (input capture, index multiply, knot
// table read, interpolation multiply, 1-exp subtract, alpha*lambda multiply,
// round and saturate), so one item is accepted every cycle while the input is
// not stalled; each result leaves from the stage 7 register. A stalled output
// backs up stage by stage; input stalls only once all seven stages hold items.
module selu_activation_core import selu_pkg::*; #(
  parameter int unsigned EXP_SEGMENTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       sample_in_valid_i,
  output logic                       sample_in_stall_o,
  output logic signed [RESULT_W-1:0] sample_out_o,
  output logic                       sample_out_valid_o,
  input  logic                       sample_out_stall_i
);

  selu_cfg_t cfg;

  selu_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  selu_pipe #(
    .EXP_SEGMENTS(EXP_SEGMENTS)
  ) u_pipe (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .sample_in_i        (sample_in_i),
    .sample_in_valid_i  (sample_in_valid_i),
    .sample_in_stall_o  (sample_in_stall_o),
    .sample_out_o       (sample_out_o),
    .sample_out_valid_o (sample_out_valid_o),
    .sample_out_stall_i (sample_out_stall_i)
  );

endmodule

// ===== sim/selu_activation_core_tb.sv =====
`timescale 1ns / 1ps

module selu_activation_core_tb;
  import selu_pkg::*;

  localparam int unsigned EXP_SEG     = 64;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned N_RANDOM    = 72;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam logic [PADDR_W-1:0] ADDR_ALPHA  = {REG_ALPHA, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_LAMBDA = {REG_LAMBDA, 2'b00};

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [RESULT_W-1:0] want;
  } selu_check_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // APB side
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Item channels
  logic signed [SAMPLE_W-1:0] sample_in   = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic signed [RESULT_W-1:0] sample_out;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;

  // Predictor state: exp knots (Q30) and the current scale registers
  longint unsigned exp_knot [0:EXP_SEG];
  logic [COEF_W-1:0] alpha_cfg  = ALPHA_RESET;
  logic [COEF_W-1:0] lambda_cfg = LAMBDA_RESET;

  logic signed [SAMPLE_W-1:0] sample_fifo [$];
  selu_check_t                selu_pending_q [$];

  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;
  int in_gap      = 0;
  int out_hold    = 0;
  int err_cnt     = 0;
  int n_sent      = 0;
  int n_queued    = 0;
  int n_checked   = 0;
  int unsigned cycle_cnt = 0;

  selu_activation_core #(
    .EXP_SEGMENTS(EXP_SEG)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .sample_in_i       (sample_in),
    .sample_in_valid_i (in_valid),
    .sample_in_stall_o (in_stall),
    .sample_out_o      (sample_out),
    .sample_out_valid_o(out_valid),
    .sample_out_stall_i(out_stall)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // SELU of one Q4.11 sample with the current alpha/lambda, Q8.11 saturated
  function automatic logic signed [RESULT_W-1:0] selu_of(input logic signed [SAMPLE_W-1:0] x);
    longint unsigned lam, al, t, pos, idx, frac, e, a, b, d, m, mag;
    longint          res;
    lam = longint'(lambda_cfg);
    al  = longint'(alpha_cfg) * lam;
    if (x >= 0) begin
      res = longint'((longint'(x) * lam + 64'd8192) >> 14);
    end else begin
      t    = -longint'(x);
      pos  = t * EXP_SEG;
      idx  = pos >> FRAC_W;
      frac = pos & 64'h7fff;
      if (idx >= EXP_SEG) begin
        e = exp_knot[EXP_SEG];
      end else begin
        a = exp_knot[idx];
        b = exp_knot[idx + 1];
        d = (a >= b) ? a - b : 64'd0;
        e = a - ((d * frac + 64'd16384) >> 15);
      end
      if (e > (64'd1 << 30)) e = 64'd1 << 30;
      m   = (64'd1 << 30) - e;
      mag = (m * al + (64'd1 << 46)) >> 47;
      res = -longint'(mag);
    end
    if (res > 524287) res = 524287;
    if (res < -524288) res = -524288;
    return res[RESULT_W-1:0];
  endfunction

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr, input logic [COEF_W-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== PDATA_W'(want)) begin
      $display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
               $time, addr, want, prdata);
      err_cnt++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Driver: presents queued samples, with a random idle gap after each accepted item when input idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    bit free;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      sample_in <= '0;
      in_gap = 0;
    end else begin
      free = !in_valid;
      if (in_valid && !in_stall) begin
        selu_pending_q.push_back('{x: sample_in, want: selu_of(sample_in)});
        n_sent++;
        in_gap = in_idle_on ? $urandom_range(0, 19) : 0;
        free = 1'b1;
      end
      if (free) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_fifo.size() != 0) begin
          sample_in <= sample_fifo.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item, then stalls for a random hold when output idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    selu_check_t chk;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (selu_pending_q.size() == 0) begin
          $display("%0t: unexpected result item %0d", $time, sample_out);
          err_cnt++;
        end else begin
          chk = selu_pending_q.pop_front();
          n_checked++;
          if (sample_out !== chk.want) begin
            $display("%0t: sample_out for x=%0d: expected %0d, got %0d",
                     $time, chk.x, chk.want, sample_out);
            err_cnt++;
          end
        end
        out_hold = out_idle_on ? $urandom_range(0, 19) : 0;
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items still pending", $time, selu_pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    longint unsigned term, sum, r;
    int directed [25] = '{0, 1, -1, 32767, -32768, -32767, 2048, -2048, -512, -511,
                          -513, -1024, -16384, 16384, -30000, 12345, -12345, -32256,
                          -32257, 21845, -21846, 1023, -1023, 4096, 2};
    int edges [8] = '{0, 1, -1, 32767, -32768, -512, -2048, 2048};
    int v;
    logic [COEF_W-1:0] a_new, l_new;

    // exp(-16k/EXP_SEG) knots: series for exp(h), reciprocal, then repeated product
    term = 64'd1 << 30;
    sum  = 0;
    for (longint unsigned n = 1; n <= 64 && term != 0; n++) begin
      sum += term;
      term = (term * 16) / (EXP_SEG * n);
    end
    if (sum == 0) sum = 64'd1 << 30;
    r = ((64'd1 << 60) + sum / 2) / sum;
    exp_knot[0] = 64'd1 << 30;
    for (int k = 1; k <= EXP_SEG; k++)
      exp_knot[k] = (exp_knot[k-1] * r + (64'd1 << 29)) >> 30;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      // Scale settings: reset values, extremes, zeros, random, back to reset
      a_new = alpha_cfg;
      l_new = lambda_cfg;
      case (p)
        1: begin a_new = 16'hffff; l_new = 16'hffff; end
        2: begin a_new = 16'd0;    l_new = LAMBDA_RESET; end
        3: begin a_new = ALPHA_RESET; l_new = 16'd0; end
        4: begin a_new = 16'd0;    l_new = 16'd0; end
        5, 6: begin
          a_new = COEF_W'($urandom_range(0, 65535));
          l_new = COEF_W'($urandom_range(0, 65535));
        end
        7: begin a_new = ALPHA_RESET; l_new = LAMBDA_RESET; end
        default: ;
      endcase
      if (p != 0) begin
        apb_write(ADDR_ALPHA, PDATA_W'(a_new));
        apb_write(ADDR_LAMBDA, PDATA_W'(l_new));
        alpha_cfg  = a_new;
        lambda_cfg = l_new;
      end
      apb_read_check(ADDR_ALPHA, alpha_cfg);
      apb_read_check(ADDR_LAMBDA, lambda_cfg);

      // some phases run back to back on one or both sides
      in_idle_on  = (p != 2 && p != 5);
      out_idle_on = (p != 3 && p != 5);

      if (p == 0) begin
        foreach (directed[i]) begin
          sample_fifo.push_back(SAMPLE_W'(directed[i]));
          n_queued++;
        end
      end else begin
        foreach (edges[i]) begin
          sample_fifo.push_back(SAMPLE_W'(edges[i]));
          n_queued++;
        end
      end

      // random mix: full range, near zero, around knot boundaries
      for (int i = 0; i < N_RANDOM; i++) begin
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 1023) - 512;
          1: v = -(512 * $urandom_range(0, 64)) + $urandom_range(0, 4) - 2;
          default: v = $urandom_range(0, 65535);
        endcase
        sample_fifo.push_back(SAMPLE_W'(v));
        n_queued++;
      end

      // drain before touching the registers again: every queued item checked
      while (n_checked < n_queued)
        @(posedge clk_i);
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d samples over %0d alpha/lambda settings, %0d results checked,",
             n_sent, N_PHASES, n_checked);
    $display("including zero and full-scale scales and the -16.0 end of the exp table.");
    if (err_cnt == 0 && selu_pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
